[rtl/spcc_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the snp pair contingency counter
// no dependencies
package spcc_pkg;

    localparam int MAX_SAMPLES_DEF = 65536;
    localparam int AB_W            = 19;
    localparam int STAT_W          = 18;
    localparam int AB_MAX          = (1 << AB_W) - 1;
    localparam int STAT_MAX        = (1 << STAT_W) - 1;
    localparam int GT_W            = 2;
    localparam int PH_W            = 8;
    localparam int IN_DATA_W       = 16;
    localparam int OUT_DATA_W      = 224;

    localparam logic [GT_W-1:0] GT_MISSING   = 2'd0;
    localparam logic [PH_W-1:0] PH_UNAFFECTED = 8'd1;
    localparam logic [PH_W-1:0] PH_AFFECTED   = 8'd2;

    typedef enum logic {
        ST_COLLECT,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic count_en;
        logic capture;
    } t_dp_cmd;

endpackage

[rtl/spcc_ctrl.sv]
`timescale 1ns / 1ps
// handshake controller: accepts transactions and tracks the pending result
// depends on spcc_pkg
module spcc_ctrl
    import spcc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    input  logic    i_s_tlast,
    input  logic    i_m_tready,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_s_tready    = (r_state == ST_COLLECT) || i_m_tready;
        o_m_tvalid    = (r_state == ST_HOLD);
        accept        = i_s_tvalid && o_s_tready;
        o_cmd.count_en = accept;
        o_cmd.capture  = accept && i_s_tlast;
        n_state       = r_state;
        unique case (r_state)
            ST_COLLECT: begin
                if (o_cmd.capture) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (o_cmd.capture) begin
                    n_state = ST_HOLD;
                end else if (i_m_tready) begin
                    n_state = ST_COLLECT;
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

endmodule

[rtl/spcc_datapath.sv]
`timescale 1ns / 1ps
// counter tables and weighted allele sums with result register
// depends on spcc_pkg
module spcc_datapath
    import spcc_pkg::*;
#(
    parameter int CNT_W = 17
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [GT_W-1:0]       i_genotype_a,
    input  logic [GT_W-1:0]       i_genotype_b,
    input  logic [PH_W-1:0]       i_phenotype_code,
    output logic [OUT_DATA_W-1:0] o_data
);

    localparam int EXT_W = (CNT_W + 4 > AB_W + 1) ? CNT_W + 4 : AB_W + 1;

    logic [CNT_W-1:0] r_pair [3][3];
    logic [CNT_W-1:0] n_pair [3][3];
    logic [CNT_W-1:0] r_fst  [3][2];
    logic [CNT_W-1:0] n_fst  [3][2];
    logic [CNT_W-1:0] r_snd  [3][2];
    logic [CNT_W-1:0] n_snd  [3][2];
    logic [OUT_DATA_W-1:0] r_data;
    logic [OUT_DATA_W-1:0] n_data;

    logic have_stat;
    logic stat_idx;
    logic [AB_W-1:0]   ab   [4];
    logic [STAT_W-1:0] fsum [4];
    logic [STAT_W-1:0] ssum [4];

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c, input logic hit);
        bump = (hit && (c != {CNT_W{1'b1}})) ? c + 1'b1 : c;
    endfunction

    function automatic logic [EXT_W-1:0] ext(input logic [CNT_W-1:0] c);
        ext = EXT_W'(c);
    endfunction

    function automatic logic [AB_W-1:0] ab_sum(input logic [CNT_W-1:0] p4,
                                               input logic [CNT_W-1:0] p2a,
                                               input logic [CNT_W-1:0] p2b,
                                               input logic [CNT_W-1:0] p1);
        logic [EXT_W-1:0] v;
        v = (ext(p4) << 2) + (ext(p2a) << 1) + (ext(p2b) << 1) + ext(p1);
        ab_sum = (v > EXT_W'(AB_MAX)) ? AB_W'(AB_MAX) : v[AB_W-1:0];
    endfunction

    function automatic logic [STAT_W-1:0] stat_sum(input logic [CNT_W-1:0] t2,
                                                   input logic [CNT_W-1:0] t1);
        logic [EXT_W-1:0] v;
        v = (ext(t2) << 1) + ext(t1);
        stat_sum = (v > EXT_W'(STAT_MAX)) ? STAT_W'(STAT_MAX) : v[STAT_W-1:0];
    endfunction

    always_comb begin
        have_stat = (i_phenotype_code == PH_UNAFFECTED) ||
                    (i_phenotype_code == PH_AFFECTED);
        stat_idx  = (i_phenotype_code == PH_AFFECTED);
        for (int ia = 0; ia < 3; ia++) begin
            for (int ib = 0; ib < 3; ib++) begin
                n_pair[ia][ib] = bump(r_pair[ia][ib], i_cmd.count_en &&
                    (i_genotype_a == GT_W'(ia + 1)) && (i_genotype_b == GT_W'(ib + 1)));
            end
            for (int is = 0; is < 2; is++) begin
                n_fst[ia][is] = bump(r_fst[ia][is], i_cmd.count_en && have_stat &&
                    (i_genotype_a == GT_W'(ia + 1)) && (stat_idx == 1'(is)));
                n_snd[ia][is] = bump(r_snd[ia][is], i_cmd.count_en && have_stat &&
                    (i_genotype_b == GT_W'(ia + 1)) && (stat_idx == 1'(is)));
            end
        end

        ab[0] = ab_sum(n_pair[0][0], n_pair[1][0], n_pair[0][1], n_pair[1][1]);
        ab[1] = ab_sum(n_pair[0][2], n_pair[1][2], n_pair[0][1], n_pair[1][1]);
        ab[2] = ab_sum(n_pair[2][0], n_pair[1][0], n_pair[2][1], n_pair[1][1]);
        ab[3] = ab_sum(n_pair[2][2], n_pair[1][2], n_pair[2][1], n_pair[1][1]);
        fsum[0] = stat_sum(n_fst[0][0], n_fst[1][0]);
        fsum[1] = stat_sum(n_fst[0][1], n_fst[1][1]);
        fsum[2] = stat_sum(n_fst[2][0], n_fst[1][0]);
        fsum[3] = stat_sum(n_fst[2][1], n_fst[1][1]);
        ssum[0] = stat_sum(n_snd[0][0], n_snd[1][0]);
        ssum[1] = stat_sum(n_snd[0][1], n_snd[1][1]);
        ssum[2] = stat_sum(n_snd[2][0], n_snd[1][0]);
        ssum[3] = stat_sum(n_snd[2][1], n_snd[1][1]);

        n_data = r_data;
        if (i_cmd.capture) begin
            n_data = {4'd0, ssum[3], ssum[2], ssum[1], ssum[0],
                      fsum[3], fsum[2], fsum[1], fsum[0],
                      ab[3], ab[2], ab[1], ab[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n || i_cmd.capture) begin
            for (int ia = 0; ia < 3; ia++) begin
                for (int ib = 0; ib < 3; ib++) begin
                    r_pair[ia][ib] <= '0;
                end
                for (int is = 0; is < 2; is++) begin
                    r_fst[ia][is] <= '0;
                    r_snd[ia][is] <= '0;
                end
            end
        end else begin
            r_pair <= n_pair;
            r_fst  <= n_fst;
            r_snd  <= n_snd;
        end
    end

    assign o_data = r_data;

endmodule

[rtl/snp_pair_contingency_counter_top.sv]
`timescale 1ns / 1ps
// the result is registered and valid in the cycle after the tlast transaction
// throughput: one transaction per cycle, unless a held result blocks the input
// every transaction stalls while a result is pending and the sink is not ready
// reset (synchronous, active low) clears all counters and the pending result
// depends on spcc_pkg, spcc_ctrl, spcc_datapath
module snp_pair_contingency_counter_top
    import spcc_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // genotype_a[1:0], genotype_b[3:2], phenotype_code[11:4], zero fill
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic                  i_s_axis_tlast,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // ab_00, ab_01, ab_10, ab_11, a_stat_00, a_stat_01, a_stat_10, a_stat_11,
    // b_stat_00, b_stat_01, b_stat_10, b_stat_11, zero fill
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

    t_dp_cmd cmd;

    spcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_s_tlast  (i_s_axis_tlast),
        .i_m_tready (i_m_axis_tready),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_cmd      (cmd)
    );

    spcc_datapath #(
        .CNT_W (CNT_W)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_genotype_a     (i_s_axis_tdata[1:0]),
        .i_genotype_b     (i_s_axis_tdata[3:2]),
        .i_phenotype_code (i_s_axis_tdata[11:4]),
        .o_data           (o_m_axis_tdata)
    );

endmodule
